@@ rtl/cs_pkg.sv @@
// Shared types, constants and the exp lookup table for the categorical sampler.
package cs_pkg;

	localparam int unsigned MAX_WEIGHTS     = 1024;
	localparam int unsigned EXP_TABLE_DEPTH = 256;

	localparam int AddrW    = $clog2(MAX_WEIGHTS);
	localparam int CntW     = AddrW + 1;
	localparam int WeightW  = 17;
	localparam int LogW     = 16;
	localparam int MapW     = 16;
	localparam int UniW     = 16;
	localparam int SumW     = AddrW + 17;
	localparam int TabW     = $clog2(EXP_TABLE_DEPTH);
	localparam int DiffIdxW = LogW - 4;

	localparam logic signed [LogW-1:0] LogMin = {1'b1, {(LogW-1){1'b0}}};
	localparam logic signed [LogW-1:0] LogMax = {1'b0, {(LogW-1){1'b1}}};

	localparam logic [63:0] Q58One = 64'h1 << 58;
	localparam logic [63:0] ExpDen = 64'd16;

	typedef logic [MapW-1:0] exp_tab_t [EXP_TABLE_DEPTH];

	typedef struct packed {
		logic load;
		logic sum_start;
		logic walk_start;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic out_free;
	} status_t;

	// Q6.58 product, truncated
	function automatic logic [63:0] mul_q58(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'b0, a} * {64'b0, b};
		return p[121:58];
	endfunction

	// floor(n / d) by restoring shift-subtract
	function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r    = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-num/16) in Q6.58 by truncated Taylor terms
	function automatic logic [63:0] exp_neg_q58(input logic [63:0] num);
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		term = Q58One;
		pos  = Q58One;
		neg  = 64'd0;
		for (int k = 1; k <= 60; k++) begin
			term = div_u64(term * num, ExpDen * 64'(k));
			if ((k & 1) == 1) begin
				neg = neg + term;
			end else begin
				pos = pos + term;
			end
		end
		return pos - neg;
	endfunction

	function automatic exp_tab_t build_exp_table();
		exp_tab_t     tab;
		logic [63:0]  frac [16];
		logic [63:0]  e1;
		logic [63:0]  whole;
		logic [63:0]  p;
		logic [127:0] r;
		logic [63:0]  q;
		e1    = exp_neg_q58(64'd16);
		whole = Q58One;
		for (int j = 0; j < 16; j++) begin
			frac[j] = exp_neg_q58(64'(j));
		end
		for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
			if (i != 0 && (i & 15) == 0) begin
				whole = mul_q58(whole, e1);
			end
			p = mul_q58(whole, frac[i & 15]);
			r = {64'b0, p} * 128'd65535 + (128'd1 << 57);
			q = r[121:58];
			tab[i] = (q > 64'd65535) ? 16'hFFFF : q[MapW-1:0];
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_table();

	// log view of a weight: saturate to the signed 16-bit range
	function automatic logic signed [LogW-1:0] log_view(input logic signed [WeightW-1:0] w);
		logic signed [LogW-1:0] v;
		if (w[WeightW-1] != w[WeightW-2]) begin
			v = w[WeightW-1] ? LogMin : LogMax;
		end else begin
			v = w[LogW-1:0];
		end
		return v;
	endfunction

endpackage

@@ rtl/cs_if.sv @@
// Stream interfaces of the categorical sampler: weight items, results, configuration.
interface cs_item_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [cs_pkg::WeightW-1:0]    weight;
	logic                                 is_last;
	logic        [cs_pkg::UniW-1:0]       uniform;
	modport source (output valid, weight, is_last, uniform, input ready);
	modport sink   (input valid, weight, is_last, uniform, output ready);
endinterface

interface cs_result_if;
	logic                       valid;
	logic                       ready;
	logic [cs_pkg::AddrW-1:0]   sample_index;
	modport source (output valid, sample_index, input ready);
	modport sink   (input valid, sample_index, output ready);
endinterface

interface cs_cfg_if;
	logic valid;
	logic ready;
	logic log_domain;
	modport source (output valid, log_domain, input ready);
	modport sink   (input valid, log_domain, output ready);
endinterface

@@ rtl/cs_ctrl.sv @@
// Sequencer of the categorical sampler: load, sum pass, threshold, walk, result.
module cs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_is_last,
	output logic            in_ready,
	output cs_pkg::cmd_t    cmd,
	input  cs_pkg::status_t status
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUM  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_WALK = 3'd3;
	localparam logic [2:0] ST_PUT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd.load       = in_valid && in_ready;
		cmd.sum_start  = in_valid && in_ready && in_is_last;
		cmd.walk_start = (state_q == ST_MUL);
		cmd.out_load   = (state_q == ST_PUT) && status.out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.sum_start) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				if (status.done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_WALK;
			end
			ST_WALK: begin
				if (status.done) begin
					state_d = ST_PUT;
				end
			end
			ST_PUT: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/cs_dp.sv @@
// Datapath: weight memory, max tracking, weight mapping pipe, sum, threshold and walk.
module cs_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cs_pkg::cmd_t                      cmd,
	output cs_pkg::status_t                   status,
	input  logic signed [cs_pkg::WeightW-1:0] weight,
	input  logic        [cs_pkg::UniW-1:0]    uniform,
	input  logic                              cfg_valid,
	input  logic                              cfg_log_domain,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic        [cs_pkg::AddrW-1:0]   sample_index
);

	logic signed [cs_pkg::WeightW-1:0] mem [cs_pkg::MAX_WEIGHTS];

	logic                             log_domain_q;
	logic [cs_pkg::CntW-1:0]          count_q;
	logic signed [cs_pkg::LogW-1:0]   rmax_q;
	logic                             issue_on_q;
	logic [cs_pkg::AddrW-1:0]         rd_addr_q;
	logic                             walk_q;
	logic                             done_q;
	logic                             out_valid_q;

	logic signed [cs_pkg::WeightW-1:0] rd_data_s1;
	logic [cs_pkg::AddrW-1:0]          idx_s1;
	logic                              last_s1;
	logic                              rd_v_s1;
	logic [cs_pkg::MapW-1:0]           mapped_s2;
	logic [cs_pkg::AddrW-1:0]          idx_s2;
	logic                              last_s2;
	logic                              v_s2;

	logic [cs_pkg::SumW-1:0]  total_q;
	logic [cs_pkg::SumW-1:0]  prefix_q;
	logic [cs_pkg::SumW-1:0]  thr_q;
	logic [cs_pkg::UniW-1:0]  uniform_q;
	logic [cs_pkg::AddrW-1:0] walk_idx_q;
	logic [cs_pkg::AddrW-1:0] sample_q;

	logic signed [cs_pkg::LogW-1:0]     lv_in;
	logic signed [cs_pkg::LogW-1:0]     lv_rd;
	logic                               has_room;
	logic [cs_pkg::CntW-1:0]            cnt_m1;
	logic                               last_issue;
	logic signed [cs_pkg::LogW:0]       diff;
	logic [cs_pkg::DiffIdxW-1:0]        idx_full;
	logic [cs_pkg::TabW-1:0]            tab_idx;
	logic [cs_pkg::MapW-1:0]            mapped;
	logic [cs_pkg::SumW-1:0]            prefix_next;
	logic                               hit;
	logic                               take_s2;
	logic [cs_pkg::SumW+cs_pkg::UniW-1:0] prod;

	assign lv_in      = cs_pkg::log_view(weight);
	assign has_room   = count_q < cs_pkg::CntW'(cs_pkg::MAX_WEIGHTS);
	assign cnt_m1     = count_q - cs_pkg::CntW'(1);
	assign last_issue = ({1'b0, rd_addr_q} == cnt_m1);

	// exp(v - max) lookup for log mode, clamped table index; linear mode clips negative weights to zero
	always_comb begin
		lv_rd    = cs_pkg::log_view(rd_data_s1);
		diff     = {rmax_q[cs_pkg::LogW-1], rmax_q} - {lv_rd[cs_pkg::LogW-1], lv_rd};
		idx_full = diff[cs_pkg::LogW-1:4];
		if (idx_full > cs_pkg::DiffIdxW'(cs_pkg::EXP_TABLE_DEPTH - 1)) begin
			tab_idx = cs_pkg::TabW'(cs_pkg::EXP_TABLE_DEPTH - 1);
		end else begin
			tab_idx = idx_full[cs_pkg::TabW-1:0];
		end
		if (log_domain_q) begin
			mapped = cs_pkg::EXP_TAB[tab_idx];
		end else if (rd_data_s1[cs_pkg::WeightW-1]) begin
			mapped = '0;
		end else begin
			mapped = rd_data_s1[cs_pkg::MapW-1:0];
		end
	end

	assign prefix_next = prefix_q + cs_pkg::SumW'(mapped_s2);
	assign hit         = prefix_next >= thr_q;
	assign take_s2     = v_s2 && !done_q;
	assign prod        = (cs_pkg::SumW + cs_pkg::UniW)'(uniform_q)
	                   * (cs_pkg::SumW + cs_pkg::UniW)'(total_q);

	always_ff @(posedge clk) begin
		if (cmd.load && has_room) begin
			mem[count_q[cs_pkg::AddrW-1:0]] <= weight;
		end
		if (issue_on_q) begin
			rd_data_s1 <= mem[rd_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_domain_q <= 1'b0;
			count_q      <= '0;
			rmax_q       <= cs_pkg::LogMin;
			issue_on_q   <= 1'b0;
			rd_addr_q    <= '0;
			walk_q       <= 1'b0;
			done_q       <= 1'b0;
			rd_v_s1      <= 1'b0;
			v_s2         <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				log_domain_q <= cfg_log_domain;
			end
			if (cmd.load && has_room) begin
				count_q <= count_q + cs_pkg::CntW'(1);
				if (lv_in > rmax_q) begin
					rmax_q <= lv_in;
				end
			end
			if (cmd.out_load) begin
				count_q <= '0;
				rmax_q  <= cs_pkg::LogMin;
			end

			if (issue_on_q) begin
				rd_addr_q <= rd_addr_q + cs_pkg::AddrW'(1);
				if (last_issue) begin
					issue_on_q <= 1'b0;
				end
			end
			rd_v_s1 <= issue_on_q;
			v_s2    <= rd_v_s1;
			if (take_s2 && (last_s2 || (walk_q && hit))) begin
				done_q     <= 1'b1;
				issue_on_q <= 1'b0;
			end

			if (cmd.sum_start || cmd.walk_start) begin
				issue_on_q <= 1'b1;
				rd_addr_q  <= '0;
				rd_v_s1    <= 1'b0;
				v_s2       <= 1'b0;
				done_q     <= 1'b0;
				walk_q     <= cmd.walk_start;
			end

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue_on_q) begin
			idx_s1  <= rd_addr_q;
			last_s1 <= last_issue;
		end
		if (rd_v_s1) begin
			mapped_s2 <= mapped;
			idx_s2    <= idx_s1;
			last_s2   <= last_s1;
		end
		if (take_s2) begin
			if (walk_q) begin
				prefix_q   <= prefix_next;
				walk_idx_q <= idx_s2;
			end else begin
				total_q <= total_q + cs_pkg::SumW'(mapped_s2);
			end
		end
		if (cmd.sum_start) begin
			total_q   <= '0;
			uniform_q <= uniform;
		end
		if (cmd.walk_start) begin
			prefix_q <= '0;
			thr_q    <= prod[cs_pkg::SumW+cs_pkg::UniW-1:cs_pkg::UniW];
		end
		if (cmd.out_load) begin
			sample_q <= walk_idx_q;
		end
	end

	assign status.done     = done_q;
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign sample_index    = sample_q;

endmodule

@@ rtl/categorical_sampler.sv @@
// Top level of the categorical sampler: inverse-CDF draw over a loaded list of weights.
//
// Channels: items (weight, is_last, uniform) in, results (sample_index) out,
// cfg (log_domain) for the mode register; every channel moves a beat when
// valid and ready are both high. cfg is always ready.
// Load: one weight beat per cycle is stored while the block is idle. Beats past
// the memory depth are dropped, but a dropped beat with is_last still draws.
// Draw: the beat with is_last starts a sum pass over the stored weights, the
// ST_MUL state forms the threshold, then a walk over the prefix sums stops at
// the first hit, and the ST_PUT state puts the index in the output register.
// Both passes run through the single read port of the weight memory, one
// entry per cycle.
// items.ready is low from the last beat until the result is registered.
// A finished result waits in the output register while new weights load; if
// it is still not taken when the next draw completes, that draw holds until
// the receiver takes the first one.
// Reset clears the mode to linear, the stored list and the output valid flag.
module categorical_sampler (
	input logic          clk,
	input logic          arst_n,
	cs_item_if.sink      items,
	cs_result_if.source  results,
	cs_cfg_if.sink       cfg
);

	cs_pkg::cmd_t    cmd;
	cs_pkg::status_t status;

	assign cfg.ready = 1'b1;

	cs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (items.valid),
		.in_is_last (items.is_last),
		.in_ready   (items.ready),
		.cmd        (cmd),
		.status     (status)
	);

	cs_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.weight         (items.weight),
		.uniform        (items.uniform),
		.cfg_valid      (cfg.valid),
		.cfg_log_domain (cfg.log_domain),
		.out_ready      (results.ready),
		.out_valid      (results.valid),
		.sample_index   (results.sample_index)
	);

endmodule

@@ rtl/cs_checker.sv @@
// Port-level assertions for the categorical sampler, bound to the top level.
module cs_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     in_is_last,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [cs_pkg::AddrW-1:0] sample_index
);

	logic [1:0] pend_q;
	logic       last_beat;
	logic       out_beat;

	assign last_beat = in_valid && in_ready && in_is_last;
	assign out_beat  = out_valid && out_ready;

	// draws requested but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else begin
			pend_q <= pend_q + {1'b0, last_beat} - {1'b0, out_beat};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_index))
		else $error("result dropped or changed while stalled");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		last_beat |=> !in_ready)
		else $error("items ready right after the last beat");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> pend_q != 2'd0)
		else $error("result beat without a pending draw");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two draws outstanding");

endmodule

bind categorical_sampler cs_checker u_cs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (items.valid),
	.in_ready     (items.ready),
	.in_is_last   (items.is_last),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.sample_index (results.sample_index)
);
